### sv/imvm_pkg.sv
// Package for the iterated matrix-vector multiply core.
// Holds beat types, command and register codes, and the MAC tag/result structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imvm_pkg;

    // Fixed field widths
    localparam int ELEM_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int IDX_FIELD_W = 6;
    localparam int CMD_W       = 2;
    localparam int SIZE_W      = 7;
    localparam int ITER_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ITER_W;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT  = 1'd1;

    localparam logic [SIZE_W-1:0] MATRIX_SIZE_RST = 7'd64;
    localparam logic [ITER_W-1:0] ITER_COUNT_RST  = 16'd1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WR_MATRIX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_VECTOR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN       = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_FIELD_W-1:0]  row_index;
        logic [IDX_FIELD_W-1:0]  col_index;
        logic signed [ELEM_W-1:0] elem_value;
    } s_beat_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0]  out_index;
        logic signed [ELEM_W-1:0] out_value;
        logic                    out_last;
        logic                    out_saturated;
    } m_beat_t;

    // Tag that travels with each operand pair into the MAC
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_tag_t;

    // Finished row sum
    typedef struct packed {
        logic                    vld;
        logic                    ovf;
        logic signed [ELEM_W-1:0] value;
    } row_result_t;

endpackage

`default_nettype wire

### sv/imvm_rowsum.sv
// Shared multiply-accumulate unit: one product per cycle, then round and saturate.
// Takes tagged operand pairs, returns one row_result_t beat per row.
// Depends on imvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imvm_rowsum #(
    parameter int MAX_SIZE    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire imvm_pkg::mac_tag_t               op_tag,
    input  wire logic signed [imvm_pkg::ELEM_W-1:0] mat_val,
    input  wire logic signed [imvm_pkg::ELEM_W-1:0] vec_val,
    output imvm_pkg::row_result_t                 result
);
    import imvm_pkg::*;

    localparam int LogSize = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int AccW    = PROD_W + LogSize + 1;
    localparam int RndW    = AccW - FRAC_W;
    localparam int SatBits = (VALUE_WIDTH < ELEM_W) ? VALUE_WIDTH : ELEM_W;

    localparam logic signed [AccW-1:0] RoundHalf =
        {{(AccW-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
    localparam logic signed [RndW-1:0] SatMax =
        {{(RndW-SatBits+1){1'b0}}, {(SatBits-1){1'b1}}};
    localparam logic signed [RndW-1:0] SatMin = ~SatMax;

    // Stage 1: product
    mac_tag_t                 tag1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Stage 2: accumulator
    logic signed [AccW-1:0]   acc_reg;
    logic signed [AccW-1:0]   acc_next;
    logic                     acc_done_reg;

    // Stage 3: rounded sum
    logic signed [AccW-1:0]   rnd_sum;
    logic signed [RndW-1:0]   rnd_reg;
    logic                     rnd_vld_reg;

    // Stage 4: saturated result
    logic signed [RndW-1:0]   clip_wide;
    logic signed [SatBits-1:0] clip_narrow;
    logic                     ovf_next;
    row_result_t              result_reg;
    row_result_t              result_next;

    assign prod_next = mat_val * vec_val;

    // Restart the sum on the first product of a row
    always_comb begin
        if (tag1_reg.first) begin
            acc_next = AccW'(prod_reg);
        end else begin
            acc_next = acc_reg + AccW'(prod_reg);
        end
    end

    // Round half up, then drop the fraction
    assign rnd_sum = acc_reg + RoundHalf;

    always_comb begin
        ovf_next  = 1'b0;
        clip_wide = rnd_reg;
        if (rnd_reg > SatMax) begin
            ovf_next  = 1'b1;
            clip_wide = SatMax;
        end else if (rnd_reg < SatMin) begin
            ovf_next  = 1'b1;
            clip_wide = SatMin;
        end
        clip_narrow       = clip_wide[SatBits-1:0];
        result_next.vld   = rnd_vld_reg;
        result_next.ovf   = ovf_next;
        result_next.value = ELEM_W'(clip_narrow);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg       <= '0;
            acc_done_reg   <= 1'b0;
            rnd_vld_reg    <= 1'b0;
            result_reg.vld <= 1'b0;
        end else begin
            tag1_reg       <= op_tag;
            acc_done_reg   <= tag1_reg.vld & tag1_reg.last;
            rnd_vld_reg    <= acc_done_reg;
            result_reg.vld <= result_next.vld;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (op_tag.vld) begin
            prod_reg <= prod_next;
        end
        if (tag1_reg.vld) begin
            acc_reg <= acc_next;
        end
        if (acc_done_reg) begin
            rnd_reg <= rnd_sum[AccW-1:FRAC_W];
        end
        if (rnd_vld_reg) begin
            result_reg.ovf   <= result_next.ovf;
            result_reg.value <= result_next.value;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### sv/iterated_matrix_vector_multiply_core.sv
// Iterated matrix-vector multiply core, signed Q16.16.
// Load beats (cmd 0 matrix entry, cmd 1 vector entry) are taken one per cycle
// while idle; a write with an index at or above MAX_SIZE is dropped, cmd 3 too.
// A run beat (cmd 2) applies y = A*x, x = y iteration_count times over an
// n x n block (n = matrix_size clamped to 1..MAX_SIZE), then streams the vector
// out as n result beats, the last one flagged, each carrying the run's sticky
// saturation flag. s_ready stays low from the run beat until the last result
// beat is taken.
// One shared multiplier feeds one accumulator, one product per cycle while a row's
// operand pairs stream in; the sequencer then waits for the MAC pipeline to drain
// the row sum through round and saturate before it starts the next row.
// Output: a stall holds each result beat in the output register and the sequencer
// waits on it. The sequencer reads, loads and presents one element at a time, with
// a single beat in flight.
// Reset (aresetn, synchronous, active low) returns to idle with matrix_size 64
// and iteration_count 1. Matrix and vector memories are not cleared.
// Depends on imvm_pkg and imvm_rowsum.
`timescale 1ns / 1ps
`default_nettype none

module iterated_matrix_vector_multiply_core #(
    parameter int MAX_SIZE    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [imvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [imvm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Command channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire imvm_pkg::s_beat_t                 s_data,
    // Result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output imvm_pkg::m_beat_t                      m_data
);
    import imvm_pkg::*;

    localparam int IdxW     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int MatDepth = MAX_SIZE * MAX_SIZE;
    localparam int MatAddrW = (MatDepth > 1) ? $clog2(MatDepth) : 1;
    localparam int VecAddrW = IdxW + 1;
    localparam int VecDepth = 2 ** VecAddrW;
    localparam logic [SIZE_W-1:0] MaxSizeS = SIZE_W'(MAX_SIZE);
    localparam logic [IdxW-1:0]   MaxLast  = IdxW'(MAX_SIZE - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MAC      = 3'd1;
    localparam logic [2:0] ST_WAIT     = 3'd2;
    localparam logic [2:0] ST_EMIT_RD  = 3'd3;
    localparam logic [2:0] ST_EMIT_LD  = 3'd4;
    localparam logic [2:0] ST_EMIT_OUT = 3'd5;

    function automatic logic [MatAddrW-1:0] mat_addr(input logic [IdxW-1:0] row,
                                                     input logic [IdxW-1:0] col);
        mat_addr = MatAddrW'(int'(row) * MAX_SIZE + int'(col));
    endfunction

    // Control registers
    logic [2:0]          state_reg, state_next;
    logic [IdxW-1:0]     row_reg, row_next;
    logic [IdxW-1:0]     col_reg, col_next;
    logic [IdxW-1:0]     n_last_reg, n_last_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [MAX_SIZE-1:0] bank_sel_reg, bank_sel_next;
    logic                sat_reg, sat_next;
    logic [SIZE_W-1:0]   cfg_size_reg;
    logic [ITER_W-1:0]   cfg_iter_reg;
    logic                m_valid_reg, m_valid_next;
    m_beat_t             m_beat_reg, m_beat_next;
    mac_tag_t            rd_tag_reg, rd_tag_next;

    // Memory ports
    logic                     mat_we;
    logic [MatAddrW-1:0]      mat_waddr;
    logic                     mat_re;
    logic [MatAddrW-1:0]      mat_raddr;
    logic signed [ELEM_W-1:0] mat_rd_reg;
    logic                     vec_we;
    logic [VecAddrW-1:0]      vec_waddr;
    logic signed [ELEM_W-1:0] vec_wdata;
    logic                     vec_re;
    logic [VecAddrW-1:0]      vec_raddr;
    logic signed [ELEM_W-1:0] vec_rd_reg;

    logic signed [ELEM_W-1:0] mat_mem [MatDepth];
    logic signed [ELEM_W-1:0] vec_mem [VecDepth];

    logic                s_accept;
    logic                row_ok;
    logic                col_ok;
    logic [IdxW-1:0]     in_row;
    logic [IdxW-1:0]     in_col;
    logic [IdxW-1:0]     run_last;
    logic [MAX_SIZE-1:0] active_mask;
    row_result_t         row_res;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid & s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_beat_reg;

    assign in_row = s_data.row_index[IdxW-1:0];
    assign in_col = s_data.col_index[IdxW-1:0];
    assign row_ok = ({1'b0, s_data.row_index} < MaxSizeS);
    assign col_ok = ({1'b0, s_data.col_index} < MaxSizeS);

    // Last index of the active block, from the clamped size
    always_comb begin
        if (cfg_size_reg == '0) begin
            run_last = '0;
        end else if (cfg_size_reg > MaxSizeS) begin
            run_last = MaxLast;
        end else begin
            run_last = IdxW'(cfg_size_reg - 7'd1);
        end
    end

    // Entries inside the active block; only these swap banks after an iteration
    always_comb begin
        for (int i = 0; i < MAX_SIZE; i++) begin
            active_mask[i] = (IdxW'(i) <= n_last_reg);
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        n_last_next   = n_last_reg;
        iter_next     = iter_reg;
        bank_sel_next = bank_sel_reg;
        sat_next      = sat_reg;
        m_valid_next  = m_valid_reg;
        m_beat_next   = m_beat_reg;
        rd_tag_next   = '0;

        mat_we    = 1'b0;
        mat_waddr = mat_addr(in_row, in_col);
        mat_re    = 1'b0;
        mat_raddr = mat_addr(row_reg, col_reg);
        vec_we    = 1'b0;
        vec_waddr = {bank_sel_reg[in_row], in_row};
        vec_wdata = s_data.elem_value;
        vec_re    = 1'b0;
        vec_raddr = {bank_sel_reg[col_reg], col_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority if (s_data.cmd == CMD_WR_MATRIX) begin
                        mat_we = row_ok & col_ok;
                    end else if (s_data.cmd == CMD_WR_VECTOR) begin
                        vec_we = row_ok;
                    end else if (s_data.cmd == CMD_RUN) begin
                        n_last_next = run_last;
                        row_next    = '0;
                        col_next    = '0;
                        sat_next    = 1'b0;
                        iter_next   = cfg_iter_reg;
                        if (cfg_iter_reg == '0) begin
                            state_next = ST_EMIT_RD;
                        end else begin
                            state_next = ST_MAC;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // Stream one row's operand pairs into the MAC
            ST_MAC: begin
                mat_re            = 1'b1;
                vec_re            = 1'b1;
                rd_tag_next.vld   = 1'b1;
                rd_tag_next.first = (col_reg == '0);
                rd_tag_next.last  = (col_reg == n_last_reg);
                if (col_reg == n_last_reg) begin
                    col_next   = '0;
                    state_next = ST_WAIT;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end

            // Row sum lands in the entry's other bank
            ST_WAIT: begin
                vec_waddr = {~bank_sel_reg[row_reg], row_reg};
                vec_wdata = row_res.value;
                if (row_res.vld) begin
                    vec_we   = 1'b1;
                    sat_next = sat_reg | row_res.ovf;
                    if (row_reg == n_last_reg) begin
                        row_next      = '0;
                        bank_sel_next = bank_sel_reg ^ active_mask;
                        iter_next     = iter_reg - 1'b1;
                        if (iter_reg == ITER_W'(1)) begin
                            state_next = ST_EMIT_RD;
                        end else begin
                            state_next = ST_MAC;
                        end
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end

            ST_EMIT_RD: begin
                vec_re     = 1'b1;
                vec_raddr  = {bank_sel_reg[row_reg], row_reg};
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD: begin
                m_beat_next.out_index     = IDX_FIELD_W'(row_reg);
                m_beat_next.out_value     = vec_rd_reg;
                m_beat_next.out_last      = (row_reg == n_last_reg);
                m_beat_next.out_saturated = sat_reg;
                m_valid_next              = 1'b1;
                state_next                = ST_EMIT_OUT;
            end

            ST_EMIT_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (row_reg == n_last_reg) begin
                        row_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            n_last_reg   <= '0;
            iter_reg     <= '0;
            bank_sel_reg <= '0;
            sat_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            rd_tag_reg   <= '0;
            cfg_size_reg <= MATRIX_SIZE_RST;
            cfg_iter_reg <= ITER_COUNT_RST;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            n_last_reg   <= n_last_next;
            iter_reg     <= iter_next;
            bank_sel_reg <= bank_sel_next;
            sat_reg      <= sat_next;
            m_valid_reg  <= m_valid_next;
            rd_tag_reg   <= rd_tag_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_MATRIX_SIZE: cfg_size_reg <= cfg_wdata[SIZE_W-1:0];
                    REG_ITER_COUNT:  cfg_iter_reg <= cfg_wdata[ITER_W-1:0];
                    default:         cfg_size_reg <= cfg_size_reg;
                endcase
            end
        end
    end

    // Output beat payload
    always_ff @(posedge aclk) begin
        m_beat_reg <= m_beat_next;
    end

    // Matrix memory
    always_ff @(posedge aclk) begin
        if (mat_we) begin
            mat_mem[mat_waddr] <= s_data.elem_value;
        end
        if (mat_re) begin
            mat_rd_reg <= mat_mem[mat_raddr];
        end
    end

    // Vector memory, two banks; a select bit per entry marks its current copy
    always_ff @(posedge aclk) begin
        if (vec_we) begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
        if (vec_re) begin
            vec_rd_reg <= vec_mem[vec_raddr];
        end
    end

    imvm_rowsum #(
        .MAX_SIZE    (MAX_SIZE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rowsum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_tag  (rd_tag_reg),
        .mat_val (mat_rd_reg),
        .vec_val (vec_rd_reg),
        .result  (row_res)
    );

endmodule

`default_nettype wire
